// ===== design/mbbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbbs_pkg
// Command and status types shared by the bounding box/sphere controller and
// its datapath.
// ----------------------------------------------------------------------------
package mbbs_pkg;

  typedef struct packed {
    logic load;        // vertex transaction accepted this cycle
    logic center;      // form center, reset scan pointer and best distance
    logic scan_step;   // read next stored vertex into the distance pipeline
    logic sqrt_start;  // launch the square root of the best distance
    logic emit;        // result on the ports, clear the mesh state
  } mbbs_cmd_t;

  typedef struct packed {
    logic scan_last;   // scan pointer sits on the last stored vertex
    logic pipe_busy;   // distance pipeline still holds work
    logic sqrt_busy;   // square root unit iterating
  } mbbs_stat_t;

endpackage

// ===== design/mesh_bounding_box_and_sphere.sv =====
// ----------------------------------------------------------------------------
// mesh_bounding_box_and_sphere
// Sequence: after the last vertex, center, rescan of the single-port vertex
//   store, pipeline drain, then one radius bit per cycle from the square
//   root unit, then the result strobe.
// Throughput: one vertex per cycle while loading; busy is high from the last
//   vertex until the result cycle ends. The receiver cannot stall.
// Reset: synchronous, active low; clears the box, vertex count and overflow.
// ----------------------------------------------------------------------------
module mesh_bounding_box_and_sphere #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_pos_z,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] out_min_x,
  output logic signed [COORD_WIDTH-1:0] out_min_y,
  output logic signed [COORD_WIDTH-1:0] out_min_z,
  output logic signed [COORD_WIDTH-1:0] out_max_x,
  output logic signed [COORD_WIDTH-1:0] out_max_y,
  output logic signed [COORD_WIDTH-1:0] out_max_z,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic signed [COORD_WIDTH-1:0] out_center_z,
  output logic [COORD_WIDTH:0]          out_radius,
  output logic                          out_overflow
);
  import mbbs_pkg::*;

  mbbs_cmd_t  cmd;
  mbbs_stat_t stat;

  mbbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .last_vertex (in_last_vertex),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  mbbs_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .pos_z    (in_pos_z),
    .min_x    (out_min_x),
    .min_y    (out_min_y),
    .min_z    (out_min_z),
    .max_x    (out_max_x),
    .max_y    (out_max_y),
    .max_z    (out_max_z),
    .center_x (out_center_x),
    .center_y (out_center_y),
    .center_z (out_center_z),
    .radius   (out_radius),
    .overflow (out_overflow)
  );

  // a closing vertex transaction always starts the rescan
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_vertex) |=> busy)
    else $error("last vertex accepted but block not busy");

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // every result covers at least one vertex, so the box is never inverted
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_min_x <= out_max_x) && (out_min_y <= out_max_y)
                   && (out_min_z <= out_max_z)))
    else $error("result box inverted");

  a_center_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_center_x >= out_min_x) && (out_center_x <= out_max_x)))
    else $error("center outside box");

endmodule

// ===== design/mbbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbbs_ctrl
// Controller: loads vertices while idle, then sequences center, rescan,
// pipeline drain, square root and result strobe.
// ----------------------------------------------------------------------------
module mbbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_vertex,
  input  mbbs_pkg::mbbs_stat_t stat,
  output mbbs_pkg::mbbs_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import mbbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CENTER   = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_DRAIN    = 7'b0001000,
    S_SQ_START = 7'b0010000,
    S_SQ_WAIT  = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start && last_vertex) state_nxt = S_CENTER;
      end
      S_CENTER:   state_nxt = S_SCAN;
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = S_SQ_START;
      end
      S_SQ_START: state_nxt = S_SQ_WAIT;
      S_SQ_WAIT: begin
        if (!stat.sqrt_busy) state_nxt = S_OUT;
      end
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.load       = start && (state_r == S_IDLE);
    cmd.center     = (state_r == S_CENTER);
    cmd.scan_step  = (state_r == S_SCAN);
    cmd.sqrt_start = (state_r == S_SQ_START);
    cmd.emit       = (state_r == S_OUT);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

// ===== design/mbbs_isqrt.sv =====
// ----------------------------------------------------------------------------
// mbbs_isqrt
// Floor integer square root, restoring digit-by-digit, one root bit per cycle.
// ----------------------------------------------------------------------------
module mbbs_isqrt #(
  parameter int OP_W = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [OP_W-1:0]     operand,
  output logic                busy,
  output logic [OP_W/2-1:0]   root
);
  localparam int RT_W  = OP_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [OP_W-1:0]  op_r;
  logic [RT_W:0]    rem_r;
  logic [RT_W-1:0]  root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [RT_W+1:0]  rem_sh;
  logic [RT_W+1:0]  trial;
  logic             fits;

  // remainder stays below 2^RT_W before each shift
  assign rem_sh = {rem_r[RT_W-1:0], op_r[OP_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(RT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r   <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      op_r <= {op_r[OP_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (RT_W+1)'(rem_sh - trial);
        root_r <= {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[RT_W:0];
        root_r <= {root_r[RT_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== design/mbbs_dp.sv =====
// ----------------------------------------------------------------------------
// mbbs_dp
// Datapath: running box, vertex store, center, squared-distance pipeline with
// running maximum, and the square root unit for the radius.
// ----------------------------------------------------------------------------
module mbbs_dp #(
  parameter int MAX_VERTICES = 1024,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mbbs_pkg::mbbs_cmd_t           cmd,
  output mbbs_pkg::mbbs_stat_t          stat,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output logic signed [COORD_WIDTH-1:0] min_x,
  output logic signed [COORD_WIDTH-1:0] min_y,
  output logic signed [COORD_WIDTH-1:0] min_z,
  output logic signed [COORD_WIDTH-1:0] max_x,
  output logic signed [COORD_WIDTH-1:0] max_y,
  output logic signed [COORD_WIDTH-1:0] max_z,
  output logic signed [COORD_WIDTH-1:0] center_x,
  output logic signed [COORD_WIDTH-1:0] center_y,
  output logic signed [COORD_WIDTH-1:0] center_z,
  output logic [COORD_WIDTH:0]          radius,
  output logic                          overflow
);
  import mbbs_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNTW  = $clog2(MAX_VERTICES + 1);
  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = 2 * CW + 2;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] pos   [3];
  logic signed [CW-1:0] min_r [3];
  logic signed [CW-1:0] max_r [3];
  logic signed [CW-1:0] cen_r [3];
  logic [CNTW-1:0]      count_r;
  logic                 ovf_r;
  logic                 full;

  logic [3*CW-1:0]      mem [MAX_VERTICES];
  logic [3*CW-1:0]      rd_r;
  logic [AW-1:0]        idx_r;

  logic signed [CW-1:0] rd_pos [3];
  logic signed [CW:0]   diff   [3];
  logic [CW-1:0]        mag_r  [3];
  logic [SQ_W-1:0]      sq_r   [3];
  logic [SUM_W-1:0]     sum_r;
  logic [SUM_W-1:0]     best_r;
  logic [3:0]           vld_r;
  logic                 sqrt_busy;

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;
  assign full   = (count_r == CNTW'(MAX_VERTICES));

  // running box and mesh bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int k = 0; k < 3; k++) begin
        min_r[k] <= COORD_MAX;
        max_r[k] <= COORD_MIN;
      end
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        if (pos[k] < min_r[k]) min_r[k] <= pos[k];
        if (pos[k] > max_r[k]) max_r[k] <= pos[k];
      end
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      mem[count_r[AW-1:0]] <= {pos_z, pos_y, pos_x};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_r <= mem[idx_r];
    end
  end

  // center is floor of the half sum
  always_ff @(posedge clk) begin
    if (cmd.center) begin
      for (int k = 0; k < 3; k++) begin
        cen_r[k] <= CW'(({min_r[k][CW-1], min_r[k]} + {max_r[k][CW-1], max_r[k]}) >>> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.center) begin
      idx_r <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], cmd.scan_step};
    end
  end

  assign rd_pos[0] = rd_r[CW-1:0];
  assign rd_pos[1] = rd_r[2*CW-1:CW];
  assign rd_pos[2] = rd_r[3*CW-1:2*CW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {rd_pos[k][CW-1], rd_pos[k]} - {cen_r[k][CW-1], cen_r[k]};
    end
  end

  // distance pipeline: magnitude, squares, sum, running maximum
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag_r[k] <= diff[k][CW] ? CW'(-diff[k]) : diff[k][CW-1:0];
      sq_r[k]  <= mag_r[k] * mag_r[k];
    end
    sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.center) begin
      best_r <= '0;
    end else if (vld_r[3] && (sum_r > best_r)) begin
      best_r <= sum_r;
    end
  end

  mbbs_isqrt #(
    .OP_W (SUM_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.sqrt_start),
    .operand (best_r),
    .busy    (sqrt_busy),
    .root    (radius)
  );

  always_comb begin
    stat.scan_last = ((CNTW'(idx_r) + 1'b1) == count_r);
    stat.pipe_busy = |vld_r;
    stat.sqrt_busy = sqrt_busy;
  end

  assign min_x    = min_r[0];
  assign min_y    = min_r[1];
  assign min_z    = min_r[2];
  assign max_x    = max_r[0];
  assign max_y    = max_r[1];
  assign max_z    = max_r[2];
  assign center_x = cen_r[0];
  assign center_y = cen_r[1];
  assign center_z = cen_r[2];
  assign overflow = ovf_r;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds mesh vertices to the bounding box and sphere block through its
// start/busy port and checks every result strobe against an in-bench model.
// The model tracks the box and the kept vertices and works out the center and
// the floor root radius. Stimulus covers corner meshes, then random meshes.
// Gaps and back-to-back bursts are mixed.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW          = 24;
  localparam int MAXV        = 1024;
  localparam int ITEMS       = 450;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum int {SPREAD_FULL, SPREAD_EDGES, SPREAD_CLUSTER, SPREAD_MIXED} spread_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
    int     gap;
    bit     drain;
  } vertex_t;

  typedef struct {
    coord_t      lo_x, lo_y, lo_z;
    coord_t      hi_x, hi_y, hi_z;
    coord_t      mid_x, mid_y, mid_z;
    logic [CW:0] radius;
    logic        ovf;
  } mesh_result_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_pos_x = '0;
  coord_t in_pos_y = '0;
  coord_t in_pos_z = '0;
  logic in_last_vertex = 1'b0;
  logic out_valid;
  coord_t out_min_x, out_min_y, out_min_z;
  coord_t out_max_x, out_max_y, out_max_z;
  coord_t out_center_x, out_center_y, out_center_z;
  logic [CW:0] out_radius;
  logic out_overflow;

  mesh_bounding_box_and_sphere #(
    .MAX_VERTICES(MAXV),
    .COORD_WIDTH (CW)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_last_vertex(in_last_vertex),
    .out_valid     (out_valid),
    .out_min_x     (out_min_x),
    .out_min_y     (out_min_y),
    .out_min_z     (out_min_z),
    .out_max_x     (out_max_x),
    .out_max_y     (out_max_y),
    .out_max_z     (out_max_z),
    .out_center_x  (out_center_x),
    .out_center_y  (out_center_y),
    .out_center_z  (out_center_z),
    .out_radius    (out_radius),
    .out_overflow  (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // model state: running box and the vertices the store keeps
  coord_t box_lo[3];
  coord_t box_hi[3];
  coord_t kept[MAXV][3];
  int     n_kept;
  bit     spilled;

  vertex_t      vertex_fifo[$];
  mesh_result_t mesh_expect[$];
  int           mismatches = 0;
  int           meshes_seen = 0;
  bit           burst = 1'b0;

  string field_name[11] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z",
                            "center_x", "center_y", "center_z", "radius", "overflow"};

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_box();
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = CMAX;
      box_hi[k] = CMIN;
    end
    n_kept  = 0;
    spilled = 1'b0;
  endfunction

  function automatic logic [CW:0] floor_root(input longint unsigned n);
    logic [CW:0] r;
    longint unsigned t;
    r = '0;
    for (int b = CW; b >= 0; b--) begin
      t = longint'(r) | (64'd1 << b);
      if (t * t <= n) r = t[CW:0];
    end
    return r;
  endfunction

  // fold one accepted vertex into the model, queue a result on the last one
  task automatic absorb_vertex(input vertex_t v);
    coord_t p[3];
    longint mid[3];
    longint d;
    longint unsigned dist_sq, far_sq;
    mesh_result_t r;
    p[0] = v.x;
    p[1] = v.y;
    p[2] = v.z;
    for (int k = 0; k < 3; k++) begin
      if (p[k] < box_lo[k]) box_lo[k] = p[k];
      if (p[k] > box_hi[k]) box_hi[k] = p[k];
    end
    if (n_kept < MAXV) begin
      for (int k = 0; k < 3; k++) kept[n_kept][k] = p[k];
      n_kept++;
    end else begin
      spilled = 1'b1;
    end
    if (v.last) begin
      far_sq = 0;
      for (int k = 0; k < 3; k++)
        mid[k] = (longint'(box_lo[k]) + longint'(box_hi[k])) >>> 1;
      for (int i = 0; i < n_kept; i++) begin
        dist_sq = 0;
        for (int k = 0; k < 3; k++) begin
          d = longint'(kept[i][k]) - mid[k];
          dist_sq += d * d;
        end
        if (dist_sq > far_sq) far_sq = dist_sq;
      end
      r.lo_x   = box_lo[0];
      r.lo_y   = box_lo[1];
      r.lo_z   = box_lo[2];
      r.hi_x   = box_hi[0];
      r.hi_y   = box_hi[1];
      r.hi_z   = box_hi[2];
      r.mid_x  = coord_t'(mid[0]);
      r.mid_y  = coord_t'(mid[1]);
      r.mid_z  = coord_t'(mid[2]);
      r.radius = floor_root(far_sq);
      r.ovf    = spilled;
      mesh_expect.push_back(r);
      clear_box();
    end
  endtask

  task automatic queue_vertex(input coord_t x, input coord_t y, input coord_t z,
                              input logic last, input bit drain);
    vertex_t v;
    v.x     = x;
    v.y     = y;
    v.z     = z;
    v.last  = last;
    v.drain = drain;
    v.gap   = burst ? 0 : $urandom_range(0, 3);
    vertex_fifo.push_back(v);
  endtask

  function automatic coord_t pick_coord(input spread_t s, input coord_t anchor);
    case (s)
      SPREAD_EDGES: begin
        case ($urandom_range(0, 5))
          0: return CMIN;
          1: return CMAX;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          4: return coord_t'(1);
          default: return coord_t'($urandom);
        endcase
      end
      SPREAD_CLUSTER: return anchor + coord_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic add_mesh(input int n, input spread_t style, input bit drain_first);
    coord_t anchor[3];
    spread_t s;
    for (int k = 0; k < 3; k++) anchor[k] = coord_t'($urandom);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      s = style;
      if (s == SPREAD_MIXED) s = spread_t'($urandom_range(0, 2));
      // vertices past the store still have to stretch the box
      if (i >= MAXV) s = SPREAD_EDGES;
      queue_vertex(pick_coord(s, anchor[0]), pick_coord(s, anchor[1]),
                   pick_coord(s, anchor[2]), i == n - 1, drain_first && i == 0);
    end
  endtask

  // driver
  int      hold_left = 0;
  bit      armed = 1'b0;
  vertex_t drv_item;

  always @(posedge clk) begin
    vertex_t nxt;
    bit go;
    if (!rst_n) begin
      start <= 1'b0;
      armed = 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) absorb_vertex(drv_item);
      if (!start || !busy) begin
        if (vertex_fifo.size() > 0) begin
          if (!armed) begin
            hold_left = vertex_fifo[0].gap;
            armed = 1'b1;
          end
          if (hold_left > 0) begin
            hold_left--;
          end else if (!(vertex_fifo[0].drain && mesh_expect.size() > 0)) begin
            nxt = vertex_fifo.pop_front();
            armed = 1'b0;
            go = 1'b1;
            drv_item = nxt;
            in_pos_x <= nxt.x;
            in_pos_y <= nxt.y;
            in_pos_z <= nxt.z;
            in_last_vertex <= nxt.last;
          end
        end
        start <= go;
      end
    end
  end

  // monitor and watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    mesh_result_t want;
    logic signed [63:0] got_f[11];
    logic signed [63:0] want_f[11];
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else if (out_valid) begin
        meshes_seen++;
        if (mesh_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d with no mesh outstanding", meshes_seen));
        end else begin
          want = mesh_expect.pop_front();
          got_f[0]  = 64'(out_min_x);     want_f[0]  = 64'(want.lo_x);
          got_f[1]  = 64'(out_min_y);     want_f[1]  = 64'(want.lo_y);
          got_f[2]  = 64'(out_min_z);     want_f[2]  = 64'(want.lo_z);
          got_f[3]  = 64'(out_max_x);     want_f[3]  = 64'(want.hi_x);
          got_f[4]  = 64'(out_max_y);     want_f[4]  = 64'(want.hi_y);
          got_f[5]  = 64'(out_max_z);     want_f[5]  = 64'(want.hi_z);
          got_f[6]  = 64'(out_center_x);  want_f[6]  = 64'(want.mid_x);
          got_f[7]  = 64'(out_center_y);  want_f[7]  = 64'(want.mid_y);
          got_f[8]  = 64'(out_center_z);  want_f[8]  = 64'(want.mid_z);
          got_f[9]  = 64'(out_radius);    want_f[9]  = 64'(want.radius);
          got_f[10] = 64'(out_overflow);  want_f[10] = 64'(want.ovf);
          for (int f = 0; f < 11; f++)
            if (got_f[f] !== want_f[f])
              report_mismatch($sformatf("mesh %0d %s: got %0d expected %0d",
                                        meshes_seen, field_name[f], got_f[f], want_f[f]));
        end
      end
    end
  end

  // stimulus and end of test
  initial begin
    int n;
    clear_box();

    // corner meshes: single points at the extremes, full-range box,
    // negative odd sums for the floor of the center
    queue_vertex(CMIN, CMIN, CMIN, 1'b1, 1'b1);
    queue_vertex(CMAX, CMAX, CMAX, 1'b1, 1'b0);
    queue_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 1'b0);
    queue_vertex(CMIN, CMIN, CMIN, 1'b0, 1'b1);
    queue_vertex(CMAX, CMAX, CMAX, 1'b1, 1'b0);
    queue_vertex(CMAX, CMIN, coord_t'(0), 1'b0, 1'b0);
    queue_vertex(CMIN, CMAX, coord_t'(-1), 1'b0, 1'b0);
    queue_vertex(coord_t'(1), coord_t'(-1), CMAX, 1'b1, 1'b0);
    queue_vertex(coord_t'(-3), coord_t'(-5), coord_t'(-7), 1'b0, 1'b1);
    queue_vertex(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 1'b0);
    queue_vertex(coord_t'(-3), coord_t'(-5), coord_t'(-7), 1'b1, 1'b0);
    queue_vertex(coord_t'(-1), coord_t'(-1), coord_t'(-1), 1'b0, 1'b0);
    queue_vertex(CMAX, coord_t'(0), CMIN, 1'b0, 1'b0);
    queue_vertex(coord_t'(12345), coord_t'(-12345), coord_t'(0), 1'b0, 1'b0);
    queue_vertex(CMIN, CMAX, CMAX, 1'b1, 1'b0);

    while (vertex_fifo.size() < ITEMS) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      add_mesh(n, spread_t'($urandom_range(0, 3)), $urandom_range(0, 5) == 0);
    end

    @(posedge rst_n);
    while (vertex_fifo.size() != 0 || start) @(negedge clk);
    while (mesh_expect.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
design/mbbs_pkg.sv
design/mbbs_ctrl.sv
design/mbbs_isqrt.sv
design/mbbs_dp.sv
design/mesh_bounding_box_and_sphere.sv
tb/testbench.sv
